FILE: hdl/st_pkg.sv
package st_pkg;

   // Widths of the result fields
   localparam int FIELD_W = 24;
   localparam int VALUE_W = 32;

   // Token kinds on the result channel
   typedef enum logic [3:0] {
      KIND_EOF     = 4'd0,
      KIND_IDENT   = 4'd1,
      KIND_LET     = 4'd2,
      KIND_CONST   = 4'd3,
      KIND_ASSIGN  = 4'd4,
      KIND_PLUS    = 4'd5,
      KIND_MINUS   = 4'd6,
      KIND_STAR    = 4'd7,
      KIND_SLASH   = 4'd8,
      KIND_PERCENT = 4'd9,
      KIND_LPAREN  = 4'd10,
      KIND_RPAREN  = 4'd11,
      KIND_SEMI    = 4'd12,
      KIND_STRING  = 4'd13,
      KIND_INT     = 4'd14,
      KIND_SBYTE   = 4'd15
   } kind_type;

   // Error codes
   typedef enum logic [1:0] {
      ERR_NONE       = 2'd0,
      ERR_INT_RANGE  = 2'd1,
      ERR_UNTERM     = 2'd2,
      ERR_UNEXPECTED = 2'd3
   } err_type;

   // One result entry
   typedef struct packed {
      kind_type             kind;
      err_type              error_code;
      logic [FIELD_W-1:0]   position;
      logic [FIELD_W-1:0]   length;
      logic [VALUE_W-1:0]   int_value;
      logic [7:0]           string_byte;
      logic                 last_of_run;
   } rsp_type;

endpackage

FILE: hdl/st_req_if.sv
interface st_req_if;

   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] ch;

   modport source (output valid, output command, output ch, input ready);
   modport sink   (input valid, input command, input ch, output ready);

endinterface

FILE: hdl/st_rsp_if.sv
interface st_rsp_if import st_pkg::*; ;

   logic               valid;
   logic               ready;
   logic [3:0]         kind;
   logic [1:0]         error_code;
   logic [FIELD_W-1:0] position;
   logic [FIELD_W-1:0] length;
   logic [VALUE_W-1:0] int_value;
   logic [7:0]         string_byte;
   logic               last_of_run;

   modport source (output valid, output kind, output error_code, output position,
                   output length, output int_value, output string_byte,
                   output last_of_run, input ready);
   modport sink   (input valid, input kind, input error_code, input position,
                   input length, input int_value, input string_byte,
                   input last_of_run, output ready);

endinterface

FILE: hdl/source_tokenizer.sv
// Channel   Dir  Payload                                              Handshake
// req_ch    in   command, ch                                          valid/ready
// rsp_ch    out  kind, error_code, position, length, int_value,      valid/ready
//                string_byte, last_of_run
//
// One request per cycle while req_ch.ready is high: the scan state updates in the
// cycle the request is taken, and its zero, one or two results enter a four-entry
// result queue. The queue drains one result per cycle while rsp_ch.ready is high,
// so a request with two results is delivered as two transfers; req_ch.ready is
// high while the queue has at least two free slots. Reset (synchronous) empties
// the queue and returns the scanner to the between-tokens state at offset zero.
module source_tokenizer import st_pkg::*; #(
   parameter int POS_BITS = 24
) (
   input  logic       clock,
   input  logic       reset,
   st_req_if.sink     req_ch,
   st_rsp_if.source   rsp_ch
);

   typedef enum logic [3:0] {
      M_START, M_IDENT, M_INT, M_SLASH, M_COLON,
      M_COMMENT, M_STRING, M_ESC, M_DRAIN
   } mode_type;

   // Character codes
   localparam logic [7:0] C_SPACE = 8'h20, C_TAB = 8'h09, C_LF = 8'h0A, C_CR = 8'h0D;
   localparam logic [7:0] C_D0 = 8'h30, C_D9 = 8'h39;
   localparam logic [7:0] C_LA = 8'h61, C_LZ = 8'h7A, C_UA = 8'h41, C_UZ = 8'h5A;
   localparam logic [7:0] C_UNDER = 8'h5F, C_SL = 8'h2F, C_COLON = 8'h3A;
   localparam logic [7:0] C_QUOTE = 8'h22, C_BSL = 8'h5C, C_EQ = 8'h3D;
   localparam logic [7:0] C_PLUS = 8'h2B, C_MINUS = 8'h2D, C_STAR = 8'h2A;
   localparam logic [7:0] C_PCT = 8'h25, C_LP = 8'h28, C_RP = 8'h29, C_SEMI = 8'h3B;
   localparam logic [7:0] C_N = 8'h6E, C_T = 8'h74, C_L = 8'h6C, C_E = 8'h65;
   localparam logic [7:0] C_C = 8'h63, C_O = 8'h6F, C_S = 8'h73;
   localparam logic [32:0] FIELD_MAX = 33'((64'd1 << FIELD_W) - 64'd1);

   // Saturate an offset or length to the result field
   function automatic logic [FIELD_W-1:0] clip(input logic [POS_BITS:0] v);
      logic [32:0] w;
      w = 33'(v);
      if (w > FIELD_MAX) return '1;
      return w[FIELD_W-1:0];
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= C_D0) && (c <= C_D9);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= C_LA) && (c <= C_LZ)) || ((c >= C_UA) && (c <= C_UZ)) ||
             (c == C_UNDER);
   endfunction

   // Keyword candidates: bit 0 let, bit 1 const
   function automatic logic [1:0] kw_next(input logic [1:0] m,
                                          input logic [POS_BITS-1:0] idx,
                                          input logic [7:0] c);
      logic let_ok, const_ok;
      let_ok   = (idx == POS_BITS'(0) && c == C_L) || (idx == POS_BITS'(1) && c == C_E) ||
                 (idx == POS_BITS'(2) && c == C_T);
      const_ok = (idx == POS_BITS'(0) && c == C_C) || (idx == POS_BITS'(1) && c == C_O) ||
                 (idx == POS_BITS'(2) && c == C_N) || (idx == POS_BITS'(3) && c == C_S) ||
                 (idx == POS_BITS'(4) && c == C_T);
      return {m[1] & const_ok, m[0] & let_ok};
   endfunction

   function automatic rsp_type mk(input kind_type k, input err_type e,
                                  input logic [FIELD_W-1:0] pos,
                                  input logic [FIELD_W-1:0] len,
                                  input logic [VALUE_W-1:0] val,
                                  input logic [7:0] sb);
      rsp_type r;
      r.kind        = k;
      r.error_code  = e;
      r.position    = pos;
      r.length      = len;
      r.int_value   = val;
      r.string_byte = sb;
      r.last_of_run = 1'b0;
      return r;
   endfunction

   // Scan state
   mode_type              mode_ff, mode_in;
   logic [POS_BITS-1:0]   pos_ff, pos_in;
   logic [POS_BITS-1:0]   tstart_ff, tstart_in;
   logic [VALUE_W-1:0]    accum_ff, accum_in;
   logic [1:0]            kwm_ff, kwm_in;

   // Result queue
   rsp_type     q_ff [4];
   logic [1:0]  head_ff, head_in, tail_ff, tail_in;
   logic [2:0]  cnt_ff, cnt_in;

   logic        fire, pop;
   logic [7:0]  c;
   logic [3:0]  digit;
   logic [POS_BITS-1:0] len_cur;
   logic [VALUE_W+3:0]  acc_next;

   // Token-start handling of a byte
   logic        st_valid;
   rsp_type     st_rsp;
   mode_type    st_mode;
   logic [VALUE_W-1:0] st_accum;
   logic [1:0]  st_kwm;
   kind_type    st_kind;

   // Pending token flush
   logic        fl_valid;
   rsp_type     fl_rsp;

   rsp_type     res_n [2];
   logic [1:0]  n_out;

   assign fire     = req_ch.valid && req_ch.ready;
   assign pop      = (cnt_ff != 3'd0) && rsp_ch.ready;
   assign c        = req_ch.ch;
   assign digit    = 4'(c - C_D0);
   assign len_cur  = pos_ff - tstart_ff;
   assign acc_next = (VALUE_W+4)'(accum_ff) * (VALUE_W+4)'(10) + (VALUE_W+4)'(digit);

   // Byte seen between tokens
   always_comb begin
      st_valid = 1'b0;
      st_mode  = M_START;
      st_accum = accum_ff;
      st_kwm   = kwm_ff;
      st_kind  = KIND_EOF;
      st_rsp   = '0;
      if (c == C_SPACE || c == C_TAB || c == C_LF || c == C_CR) begin
         st_mode = M_START;
      end else if (is_digit(c)) begin
         st_mode  = M_INT;
         st_accum = VALUE_W'(digit);
      end else if (is_alpha(c)) begin
         st_mode = M_IDENT;
         st_kwm  = {c == C_C, c == C_L};
      end else if (c == C_SL) begin
         st_mode = M_SLASH;
      end else if (c == C_COLON) begin
         st_mode = M_COLON;
      end else if (c == C_QUOTE) begin
         st_mode = M_STRING;
      end else begin
         st_valid = 1'b1;
         unique case (c)
            C_PLUS:  st_kind = KIND_PLUS;
            C_MINUS: st_kind = KIND_MINUS;
            C_STAR:  st_kind = KIND_STAR;
            C_PCT:   st_kind = KIND_PERCENT;
            C_LP:    st_kind = KIND_LPAREN;
            C_RP:    st_kind = KIND_RPAREN;
            C_SEMI:  st_kind = KIND_SEMI;
            default: st_kind = KIND_EOF;
         endcase
         if (st_kind == KIND_EOF) begin
            st_rsp  = mk(KIND_EOF, ERR_UNEXPECTED, clip((POS_BITS+1)'(pos_ff)), '0, '0, '0);
            st_mode = M_DRAIN;
         end else begin
            st_rsp = mk(st_kind, ERR_NONE, clip((POS_BITS+1)'(pos_ff)), FIELD_W'(1), '0, '0);
         end
      end
   end

   // Pending IDENT, INT or slash
   always_comb begin
      fl_valid = 1'b0;
      fl_rsp   = '0;
      unique case (mode_ff)
         M_IDENT: begin
            fl_valid = 1'b1;
            if (len_cur == POS_BITS'(3) && kwm_ff[0])
               fl_rsp = mk(KIND_LET, ERR_NONE, clip((POS_BITS+1)'(tstart_ff)),
                           clip((POS_BITS+1)'(len_cur)), '0, '0);
            else if (len_cur == POS_BITS'(5) && kwm_ff[1])
               fl_rsp = mk(KIND_CONST, ERR_NONE, clip((POS_BITS+1)'(tstart_ff)),
                           clip((POS_BITS+1)'(len_cur)), '0, '0);
            else
               fl_rsp = mk(KIND_IDENT, ERR_NONE, clip((POS_BITS+1)'(tstart_ff)),
                           clip((POS_BITS+1)'(len_cur)), '0, '0);
         end
         M_INT: begin
            fl_valid = 1'b1;
            fl_rsp   = mk(KIND_INT, ERR_NONE, clip((POS_BITS+1)'(tstart_ff)),
                          clip((POS_BITS+1)'(len_cur)), accum_ff, '0);
         end
         M_SLASH: begin
            fl_valid = 1'b1;
            fl_rsp   = mk(KIND_SLASH, ERR_NONE, clip((POS_BITS+1)'(tstart_ff)),
                          FIELD_W'(1), '0, '0);
         end
         default: fl_valid = 1'b0;
      endcase
   end

   // Next scan state and the results of this request
   always_comb begin
      mode_in   = mode_ff;
      pos_in    = pos_ff;
      tstart_in = tstart_ff;
      accum_in  = accum_ff;
      kwm_in    = kwm_ff;
      res_n[0]  = '0;
      res_n[1]  = '0;
      n_out     = 2'd0;

      if (req_ch.command) begin
         // End of source: flush, report, EOF, back to reset state
         if (fl_valid) begin
            res_n[n_out[0]] = fl_rsp;
            n_out = n_out + 2'd1;
         end else if (mode_ff == M_COLON) begin
            res_n[n_out[0]] = mk(KIND_EOF, ERR_UNEXPECTED,
                                 clip((POS_BITS+1)'(tstart_ff)), '0, '0, '0);
            n_out = n_out + 2'd1;
         end else if (mode_ff == M_STRING || mode_ff == M_ESC) begin
            res_n[n_out[0]] = mk(KIND_EOF, ERR_UNTERM,
                                 clip((POS_BITS+1)'(tstart_ff)), '0, '0, '0);
            n_out = n_out + 2'd1;
         end
         res_n[n_out[0]] = mk(KIND_EOF, ERR_NONE, clip((POS_BITS+1)'(pos_ff)), '0, '0, '0);
         n_out     = n_out + 2'd1;
         mode_in   = M_START;
         pos_in    = '0;
         tstart_in = '0;
         accum_in  = '0;
         kwm_in    = 2'b11;
      end else begin
         unique case (mode_ff)
            M_IDENT: begin
               if (is_alpha(c) || is_digit(c)) begin
                  kwm_in = kw_next(kwm_ff, len_cur, c);
               end else begin
                  res_n[0]  = fl_rsp;
                  res_n[1]  = st_rsp;
                  n_out     = st_valid ? 2'd2 : 2'd1;
                  mode_in   = st_mode;
                  tstart_in = pos_ff;
                  accum_in  = st_accum;
                  kwm_in    = st_kwm;
               end
            end
            M_INT: begin
               if (is_digit(c)) begin
                  if (acc_next > (VALUE_W+4)'({VALUE_W{1'b1}})) begin
                     res_n[0] = mk(KIND_EOF, ERR_INT_RANGE,
                                   clip((POS_BITS+1)'(tstart_ff)), '0, '0, '0);
                     n_out    = 2'd1;
                     mode_in  = M_DRAIN;
                  end else begin
                     accum_in = acc_next[VALUE_W-1:0];
                  end
               end else begin
                  res_n[0]  = fl_rsp;
                  res_n[1]  = st_rsp;
                  n_out     = st_valid ? 2'd2 : 2'd1;
                  mode_in   = st_mode;
                  tstart_in = pos_ff;
                  accum_in  = st_accum;
                  kwm_in    = st_kwm;
               end
            end
            M_SLASH: begin
               if (c == C_SL) begin
                  mode_in = M_COMMENT;
               end else begin
                  res_n[0]  = fl_rsp;
                  res_n[1]  = st_rsp;
                  n_out     = st_valid ? 2'd2 : 2'd1;
                  mode_in   = st_mode;
                  tstart_in = pos_ff;
                  accum_in  = st_accum;
                  kwm_in    = st_kwm;
               end
            end
            M_COLON: begin
               n_out = 2'd1;
               if (c == C_EQ) begin
                  res_n[0] = mk(KIND_ASSIGN, ERR_NONE, clip((POS_BITS+1)'(tstart_ff)),
                                FIELD_W'(2), '0, '0);
                  mode_in  = M_START;
               end else begin
                  res_n[0] = mk(KIND_EOF, ERR_UNEXPECTED,
                                clip((POS_BITS+1)'(tstart_ff)), '0, '0, '0);
                  mode_in  = M_DRAIN;
               end
            end
            M_COMMENT: begin
               if (c == C_LF) mode_in = M_START;
            end
            M_STRING: begin
               if (c == C_QUOTE) begin
                  res_n[0] = mk(KIND_STRING, ERR_NONE, clip((POS_BITS+1)'(tstart_ff)),
                                clip((POS_BITS+1)'(len_cur) + (POS_BITS+1)'(1)), '0, '0);
                  n_out    = 2'd1;
                  mode_in  = M_START;
               end else if (c == C_BSL) begin
                  mode_in = M_ESC;
               end else begin
                  res_n[0] = mk(KIND_SBYTE, ERR_NONE, clip((POS_BITS+1)'(pos_ff)),
                                '0, '0, c);
                  n_out    = 2'd1;
               end
            end
            M_ESC: begin
               // Unknown escapes keep the byte as is
               priority if (c == C_N)
                  res_n[0] = mk(KIND_SBYTE, ERR_NONE, clip((POS_BITS+1)'(pos_ff)),
                                '0, '0, C_LF);
               else if (c == C_T)
                  res_n[0] = mk(KIND_SBYTE, ERR_NONE, clip((POS_BITS+1)'(pos_ff)),
                                '0, '0, C_TAB);
               else
                  res_n[0] = mk(KIND_SBYTE, ERR_NONE, clip((POS_BITS+1)'(pos_ff)),
                                '0, '0, c);
               n_out   = 2'd1;
               mode_in = M_STRING;
            end
            M_DRAIN: begin
               mode_in = M_DRAIN;
            end
            default: begin
               res_n[0]  = st_rsp;
               n_out     = st_valid ? 2'd1 : 2'd0;
               mode_in   = st_mode;
               tstart_in = pos_ff;
               accum_in  = st_accum;
               kwm_in    = st_kwm;
            end
         endcase
         if (pos_ff != '1) pos_in = pos_ff + POS_BITS'(1);
      end

      // Mark the final result of this request
      if (n_out == 2'd2)      res_n[1].last_of_run = 1'b1;
      else if (n_out == 2'd1) res_n[0].last_of_run = 1'b1;
   end

   // Queue pointers
   always_comb begin
      tail_in = tail_ff;
      head_in = head_ff;
      if (fire) tail_in = tail_ff + n_out;
      if (pop)  head_in = head_ff + 2'd1;
      cnt_in = cnt_ff + (fire ? 3'(n_out) : 3'd0) - 3'(pop);
   end

   // Control and scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= M_START;
         pos_ff    <= '0;
         tstart_ff <= '0;
         accum_ff  <= '0;
         kwm_ff    <= 2'b11;
         head_ff   <= '0;
         tail_ff   <= '0;
         cnt_ff    <= '0;
      end else begin
         if (fire) begin
            mode_ff   <= mode_in;
            pos_ff    <= pos_in;
            tstart_ff <= tstart_in;
            accum_ff  <= accum_in;
            kwm_ff    <= kwm_in;
         end
         head_ff <= head_in;
         tail_ff <= tail_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Result storage
   always_ff @(posedge clock) begin
      if (fire && n_out != 2'd0) q_ff[tail_ff] <= res_n[0];
      if (fire && n_out == 2'd2) q_ff[tail_ff + 2'd1] <= res_n[1];
   end

   assign req_ch.ready = (cnt_ff <= 3'd2);

   assign rsp_ch.valid       = (cnt_ff != 3'd0);
   assign rsp_ch.kind        = q_ff[head_ff].kind;
   assign rsp_ch.error_code  = q_ff[head_ff].error_code;
   assign rsp_ch.position    = q_ff[head_ff].position;
   assign rsp_ch.length      = q_ff[head_ff].length;
   assign rsp_ch.int_value   = q_ff[head_ff].int_value;
   assign rsp_ch.string_byte = q_ff[head_ff].string_byte;
   assign rsp_ch.last_of_run = q_ff[head_ff].last_of_run;

endmodule
